// ----- sv/ert_pkg.sv -----
package ert_pkg;

   localparam int NUM_CATEGORIES_DEF = 8;

   localparam int CAT_W     = 3;
   localparam int TAG_W     = 16;
   localparam int COUNT_W   = 32;
   localparam int TIME_W    = 32;
   localparam int TIMEOUT_W = 16;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd5;

   typedef enum logic {
      OP_EVENT = 1'b0,
      OP_TICK  = 1'b1
   } op_type;

   typedef enum logic {
      KIND_IMMEDIATE = 1'b0,
      KIND_SUMMARY   = 1'b1
   } kind_type;

   typedef struct packed {
      op_type             operation;
      logic [CAT_W-1:0]   category;
      logic [TAG_W-1:0]   message_tag;
   } req_type;

   typedef struct packed {
      kind_type           report_kind;
      logic [CAT_W-1:0]   report_category;
      logic [TAG_W-1:0]   report_tag;
      logic [COUNT_W-1:0] repeat_count;
      logic [TIME_W-1:0]  elapsed_seconds;
      logic               last_of_run;
   } rsp_type;

   typedef logic [TIMEOUT_W-1:0] csr_type;

   // front to back command queue head
   typedef struct packed {
      logic    valid;
      req_type cmd;
   } cmd_chan_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } back_state_type;

endpackage

// ----- sv/ert_stream_if.sv -----
interface ert_stream_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

// ----- sv/ert_front.sv -----
module ert_front #(
   parameter int NUM_CATEGORIES = ert_pkg::NUM_CATEGORIES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   ert_stream_if.sink           req_port,
   output ert_pkg::cmd_chan_type cmd_out,
   input  logic                 cmd_pop
);

   import ert_pkg::*;

   localparam int DEPTH = 2;

   req_type    entry_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;

   logic accept;
   logic keep;
   logic pop;

   assign req_port.ready = (fill_ff != 2'(DEPTH));
   assign accept         = req_port.valid && req_port.ready;

   // events on categories beyond the configured range are dropped here
   assign keep = accept &&
                 ((req_port.payload.operation == OP_TICK) ||
                  (int'(req_port.payload.category) < NUM_CATEGORIES));

   assign pop = cmd_pop && (fill_ff != 2'd0);

   assign cmd_out.valid = (fill_ff != 2'd0);
   assign cmd_out.cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = keep ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (keep && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (!keep && pop) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (keep) begin
         entry_ff[wr_ptr_ff] <= req_port.payload;
      end
   end

endmodule

// ----- sv/ert_back.sv -----
module ert_back #(
   parameter int NUM_CATEGORIES = ert_pkg::NUM_CATEGORIES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ert_pkg::cmd_chan_type               cmd_in,
   output logic                               cmd_pop,
   input  logic [ert_pkg::TIMEOUT_W-1:0]      timeout,
   ert_stream_if.source                       rsp_port
);

   import ert_pkg::*;

   // only categories reachable through the category field can ever wait
   localparam int MAX_SLOTS = 2 ** CAT_W;
   localparam int NUM_SLOTS = (NUM_CATEGORIES < MAX_SLOTS) ? NUM_CATEGORIES : MAX_SLOTS;
   localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   back_state_type       state_ff, state_in;
   logic [SLOT_W-1:0]    scan_idx_ff, scan_idx_in;
   logic [TIME_W-1:0]    now_ff, now_in;
   logic                 held_valid_ff, held_valid_in;
   rsp_type              held_ff;
   logic                 out_valid_ff, out_valid_in;
   rsp_type              out_ff;

   logic                 waiting_ff [NUM_SLOTS];
   logic [TIME_W-1:0]    last_ff    [NUM_SLOTS];
   logic [COUNT_W-1:0]   count_ff   [NUM_SLOTS];
   logic [TAG_W-1:0]     tag_ff     [NUM_SLOTS];

   logic [SLOT_W-1:0]    sel_idx;
   logic                 sel_waiting;
   logic [TIME_W-1:0]    sel_last;
   logic [COUNT_W-1:0]   sel_count;
   logic [TAG_W-1:0]     sel_tag;
   logic [TIME_W-1:0]    elapsed;
   logic                 due;
   logic                 out_free;
   logic                 scan_last;

   logic                 tick_start;
   logic                 ev_start;
   logic                 ev_bump;
   logic                 step;
   logic                 sum_emit;
   logic                 slot_clear;
   logic                 held_clear;
   logic                 push;
   rsp_type              push_data;
   rsp_type              sum_data;

   assign sel_idx     = (state_ff == ST_SCAN) ? scan_idx_ff : cmd_in.cmd.category[SLOT_W-1:0];
   assign sel_waiting = waiting_ff[sel_idx];
   assign sel_last    = last_ff[sel_idx];
   assign sel_count   = count_ff[sel_idx];
   assign sel_tag     = tag_ff[sel_idx];
   assign elapsed     = now_ff - sel_last;
   assign due         = sel_waiting && (elapsed >= TIME_W'(timeout));
   assign out_free    = !out_valid_ff || rsp_port.ready;
   assign scan_last   = (scan_idx_ff == SLOT_W'(NUM_SLOTS - 1));

   always_comb begin
      sum_data.report_kind     = KIND_SUMMARY;
      sum_data.report_category = CAT_W'(sel_idx);
      sum_data.report_tag      = sel_tag;
      sum_data.repeat_count    = sel_count;
      sum_data.elapsed_seconds = elapsed;
      sum_data.last_of_run     = 1'b0;
   end

   // control outputs
   always_comb begin
      cmd_pop    = 1'b0;
      tick_start = 1'b0;
      ev_start   = 1'b0;
      ev_bump    = 1'b0;
      step       = 1'b0;
      sum_emit   = 1'b0;
      slot_clear = 1'b0;
      held_clear = 1'b0;
      push       = 1'b0;
      push_data  = held_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_in.valid) begin
               if (cmd_in.cmd.operation == OP_TICK) begin
                  cmd_pop    = 1'b1;
                  tick_start = 1'b1;
               end else if (sel_waiting) begin
                  cmd_pop = 1'b1;
                  ev_bump = 1'b1;
               end else if (out_free) begin
                  cmd_pop  = 1'b1;
                  ev_start = 1'b1;
                  push     = 1'b1;
                  push_data.report_kind     = KIND_IMMEDIATE;
                  push_data.report_category = cmd_in.cmd.category;
                  push_data.report_tag      = cmd_in.cmd.message_tag;
                  push_data.repeat_count    = '0;
                  push_data.elapsed_seconds = '0;
                  push_data.last_of_run     = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            // a new summary displaces the held one, which needs the output free
            if (!(due && (sel_count != '0) && held_valid_ff && !out_free)) begin
               step = 1'b1;
               if (due && (sel_count != '0)) begin
                  sum_emit = 1'b1;
                  if (held_valid_ff) begin
                     push = 1'b1;
                  end
               end else if (due) begin
                  slot_clear = 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               push                  = 1'b1;
               held_clear            = 1'b1;
               push_data.last_of_run = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (tick_start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (step && scan_last) begin
               state_in = (held_valid_ff || sum_emit) ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      scan_idx_in = scan_idx_ff;
      if (tick_start || (step && scan_last)) begin
         scan_idx_in = '0;
      end else if (step) begin
         scan_idx_in = SLOT_W'(scan_idx_ff + 1'b1);
      end
      now_in        = tick_start ? (now_ff + 1'b1) : now_ff;
      held_valid_in = sum_emit ? 1'b1 : (held_clear ? 1'b0 : held_valid_ff);
      out_valid_in  = push ? 1'b1 : (rsp_port.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         scan_idx_ff   <= '0;
         now_ff        <= '0;
         held_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            waiting_ff[i] <= 1'b0;
         end
      end else begin
         state_ff      <= state_in;
         scan_idx_ff   <= scan_idx_in;
         now_ff        <= now_in;
         held_valid_ff <= held_valid_in;
         out_valid_ff  <= out_valid_in;
         if (ev_start) begin
            waiting_ff[sel_idx] <= 1'b1;
         end
         if (slot_clear) begin
            waiting_ff[sel_idx] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ev_start) begin
         tag_ff[sel_idx]   <= cmd_in.cmd.message_tag;
         last_ff[sel_idx]  <= now_ff;
         count_ff[sel_idx] <= '0;
      end
      if (ev_bump && (sel_count != '1)) begin
         count_ff[sel_idx] <= sel_count + 1'b1;
      end
      if (sum_emit) begin
         count_ff[sel_idx] <= '0;
         last_ff[sel_idx]  <= now_ff;
         held_ff           <= sum_data;
      end
      if (push) begin
         out_ff <= push_data;
      end
   end

   assign rsp_port.valid   = out_valid_ff;
   assign rsp_port.payload = out_ff;

endmodule

// ----- sv/event_report_throttle_unit.sv -----
// Per-category event throttle. An event on an idle category is reported at once
// and the category starts waiting; further events on it are only counted. Each
// tick advances the seconds counter and scans the categories, emitting a repeat
// summary or returning a category to idle once its timeout has run out.
// Transactions enter a two-deep queue, so requests keep being taken while the
// response side stalls, until the queue is full. A tick leaves the queue, then
// the min(NUM_CATEGORIES, 8) categories pass one at a time through the single
// shared elapsed-time subtract and compare, and the final summary, if any, is
// then released; the response side can hold off both the scan and the release.
module event_report_throttle_unit #(
   parameter int NUM_CATEGORIES = ert_pkg::NUM_CATEGORIES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   ert_stream_if.sink   req_port,
   ert_stream_if.source rsp_port,
   ert_stream_if.sink   csr_port
);

   import ert_pkg::*;

   csr_type      timeout_ff, timeout_in;
   cmd_chan_type cmd_chan;
   logic         cmd_pop;

   assign csr_port.ready = 1'b1;
   assign timeout_in     = csr_port.valid ? csr_port.payload : timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   ert_front #(
      .NUM_CATEGORIES (NUM_CATEGORIES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .cmd_out  (cmd_chan),
      .cmd_pop  (cmd_pop)
   );

   ert_back #(
      .NUM_CATEGORIES (NUM_CATEGORIES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_in   (cmd_chan),
      .cmd_pop  (cmd_pop),
      .timeout  (timeout_ff),
      .rsp_port (rsp_port)
   );

endmodule
